// File: rtl/rcrs_pkg.sv
// Shared types, constants and fixed-point helpers for the ray/circle range sensor.
// Used by the top level, the front end, the back end and the testbench; depends on nothing.
package rcrs_pkg;

  // Default and derived widths.
  localparam int POS_W_DEF       = 16;
  localparam int QUEUE_DEPTH_DEF = 2;
  localparam int QUAT_W          = 16;
  localparam int CS_W            = 16;   // Q1.14 cosine or sine, signed
  localparam int DIR_W           = 17;   // rotated ray direction, signed Q2.14
  localparam int WIDE_W          = 64;   // working width of rounding arithmetic
  localparam int ISQ_W           = 58;   // squared heading length a^2 + b^2
  localparam int HEAD_W          = 29;   // heading component magnitude after /16
  localparam int QUO_W           = 15;   // normalized quotient magnitude
  localparam int SIDX_W          = 2;

  // Reset values of the obstacle registers.
  localparam int OBS_X_RST  = 6144;
  localparam int OBS_Y_RST  = 2048;
  localparam int RADIUS_RST = 1229;
  localparam int LIMIT_RST  = 2048;

  // Mount geometry in Q3.12 and Q1.14.
  localparam logic signed [15:0] MOUNT_OFS = 16'sd307;
  localparam logic signed [15:0] DIAG_Q14  = 16'sd11585;
  localparam logic signed [15:0] ONE_Q14   = 16'sd16384;

  // Sensor codes.
  localparam logic [SIDX_W-1:0] SENS_LEFT   = 2'd0;
  localparam logic [SIDX_W-1:0] SENS_CENTER = 2'd1;
  localparam logic [SIDX_W-1:0] SENS_RIGHT  = 2'd2;

  // Register indexes of the configuration port.
  typedef enum logic [1:0] {
    REG_OBS_X  = 2'd0,
    REG_OBS_Y  = 2'd1,
    REG_RADIUS = 2'd2,
    REG_LIMIT  = 2'd3
  } reg_idx_t;

  // Divide by 2^14, rounding to nearest with halves away from zero.
  function automatic logic signed [WIDE_W-1:0] rnd14(input logic signed [WIDE_W-1:0] v);
    logic [WIDE_W-1:0] m;
    logic [WIDE_W-1:0] r;
    m = v[WIDE_W-1] ? WIDE_W'(-v) : WIDE_W'(v);
    r = (m + WIDE_W'(8192)) >> 14;
    return v[WIDE_W-1] ? -$signed(r) : $signed(r);
  endfunction

  // Lateral mount offset of each sensor.
  function automatic logic signed [15:0] mount_y(input logic [SIDX_W-1:0] k);
    logic signed [15:0] v;
    case (k)
      SENS_LEFT:   v = MOUNT_OFS;
      SENS_RIGHT:  v = -MOUNT_OFS;
      default:     v = 16'sd0;
    endcase
    return v;
  endfunction

  // Forward component of each sensor direction.
  function automatic logic signed [15:0] aim_x(input logic [SIDX_W-1:0] k);
    logic signed [15:0] v;
    case (k)
      SENS_CENTER: v = ONE_Q14;
      default:     v = DIAG_Q14;
    endcase
    return v;
  endfunction

  // Lateral component of each sensor direction.
  function automatic logic signed [15:0] aim_y(input logic [SIDX_W-1:0] k);
    logic signed [15:0] v;
    case (k)
      SENS_LEFT:   v = DIAG_Q14;
      SENS_RIGHT:  v = -DIAG_Q14;
      default:     v = 16'sd0;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/ray_circle_range_sensor.sv
// Top level of the ray/circle range sensor: obstacle registers, front end, queue and back end.
// Depends on rcrs_pkg, rcrs_front, rcrs_queue and rcrs_back.
//
//   channel  | direction | handshake              | word
//   in_      | input     | in_valid / in_ready    | pose x/y, quaternion x/y/z/w
//   out_     | output    | out_valid / out_ready  | sensor index, hit, hit x/y, distance, last
//   APB      | input     | psel/penable/pwrite    | obstacle x/y, radius, range limit
//
// In the front end a pose passes through the 29-step square root and the 15-step divisions,
// both skipped with a degenerate heading. In the back end each sensor on a hit path passes
// through a POS_WIDTH-1 step square root, skipped on a miss; the back end pops the next pose
// only after the right sensor's word is registered, and an output stall holds it.
// Reset (rst_n low at a clock edge) empties both ends and the queue and loads register defaults.
// While the back end or output stalls, the front end still queues poses until the queue fills.
module ray_circle_range_sensor
  import rcrs_pkg::*;
#(
  parameter int POS_WIDTH   = POS_W_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [POS_WIDTH-1:0] in_pose_x,
  input  logic signed [POS_WIDTH-1:0] in_pose_y,
  input  logic signed [QUAT_W-1:0]    in_quat_x,
  input  logic signed [QUAT_W-1:0]    in_quat_y,
  input  logic signed [QUAT_W-1:0]    in_quat_z,
  input  logic signed [QUAT_W-1:0]    in_quat_w,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [SIDX_W-1:0]           out_sensor_index,
  output logic                        out_hit,
  output logic signed [POS_WIDTH-1:0] out_hit_x,
  output logic signed [POS_WIDTH-1:0] out_hit_y,
  output logic [POS_WIDTH-2:0]        out_distance,
  output logic                        out_last,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [3:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  localparam int QW = 2 * POS_WIDTH + 2 * CS_W;

  logic [POS_WIDTH-1:0] obs_x_r, obs_y_r;
  logic [POS_WIDTH-2:0] radius_r, limit_r;
  reg_idx_t             reg_idx;
  logic                 wr_en;

  logic                 push_valid, push_ready, pop_valid, pop_ready;
  logic [QW-1:0]        push_data, pop_data;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  // Obstacle registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      obs_x_r  <= POS_WIDTH'(OBS_X_RST);
      obs_y_r  <= POS_WIDTH'(OBS_Y_RST);
      radius_r <= (POS_WIDTH - 1)'(RADIUS_RST);
      limit_r  <= (POS_WIDTH - 1)'(LIMIT_RST);
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_OBS_X:  obs_x_r  <= pwdata[POS_WIDTH-1:0];
        REG_OBS_Y:  obs_y_r  <= pwdata[POS_WIDTH-1:0];
        REG_RADIUS: radius_r <= pwdata[POS_WIDTH-2:0];
        REG_LIMIT:  limit_r  <= pwdata[POS_WIDTH-2:0];
        default: begin
        end
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (reg_idx)
      REG_OBS_X:  prdata = 32'(obs_x_r);
      REG_OBS_Y:  prdata = 32'(obs_y_r);
      REG_RADIUS: prdata = 32'(radius_r);
      REG_LIMIT:  prdata = 32'(limit_r);
      default:    prdata = '0;
    endcase
  end

  rcrs_front #(
    .POS_WIDTH (POS_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_pose_x  (in_pose_x),
    .in_pose_y  (in_pose_y),
    .in_quat_x  (in_quat_x),
    .in_quat_y  (in_quat_y),
    .in_quat_z  (in_quat_z),
    .in_quat_w  (in_quat_w),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  rcrs_queue #(
    .W     (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  rcrs_back #(
    .POS_WIDTH (POS_WIDTH)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .pop_valid        (pop_valid),
    .pop_ready        (pop_ready),
    .pop_data         (pop_data),
    .obs_x            (obs_x_r),
    .obs_y            (obs_y_r),
    .radius           (radius_r),
    .limit            (limit_r),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_sensor_index (out_sensor_index),
    .out_hit          (out_hit),
    .out_hit_x        (out_hit_x),
    .out_hit_y        (out_hit_y),
    .out_distance     (out_distance),
    .out_last         (out_last)
  );

endmodule

// File: rtl/rcrs_isqrt.sv
// Iterative integer square root, one result bit per cycle.
// Depends on nothing; used by the front and the back of the range sensor.
module rcrs_isqrt #(
  parameter int IN_W = 58
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [IN_W-1:0]   x_in,
  output logic              done,
  output logic [IN_W/2-1:0] root
);

  localparam int RW    = IN_W / 2;
  localparam int CNT_W = $clog2(RW + 1);

  logic              busy_r;
  logic              done_r;
  logic [IN_W-1:0]   rem_r;
  logic [IN_W-1:0]   res_r;
  logic [IN_W-1:0]   bit_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [IN_W-1:0]   trial;

  assign trial = res_r + bit_r;
  assign done  = done_r;
  assign root  = res_r[RW-1:0];

  // Control: busy until the step count runs out, then a one-cycle done pulse.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // Datapath: classic remainder/trial-bit recurrence.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= x_in;
      res_r <= '0;
      bit_r <= IN_W'(1) << (IN_W - 2);
      cnt_r <= CNT_W'(RW);
    end else if (busy_r) begin
      if (rem_r >= trial) begin
        rem_r <= rem_r - trial;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
      cnt_r <= cnt_r - CNT_W'(1);
    end
  end

endmodule

// File: rtl/rcrs_front.sv
// Front end: takes a pose word and turns the quaternion into a unit cosine/sine pair.
// Depends on rcrs_pkg and rcrs_isqrt; feeds the pose queue.
module rcrs_front
  import rcrs_pkg::*;
#(
  parameter int POS_WIDTH = POS_W_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [POS_WIDTH-1:0]       in_pose_x,
  input  logic signed [POS_WIDTH-1:0]       in_pose_y,
  input  logic signed [QUAT_W-1:0]          in_quat_x,
  input  logic signed [QUAT_W-1:0]          in_quat_y,
  input  logic signed [QUAT_W-1:0]          in_quat_z,
  input  logic signed [QUAT_W-1:0]          in_quat_w,
  output logic                              push_valid,
  input  logic                              push_ready,
  output logic [2*POS_WIDTH+2*CS_W-1:0]     push_data
);

  localparam int DCNT_W = $clog2(QUO_W + 1);

  typedef enum logic [6:0] {
    F_IDLE = 7'b0000001,
    F_AB   = 7'b0000010,
    F_SQ   = 7'b0000100,
    F_SQST = 7'b0001000,
    F_SQW  = 7'b0010000,
    F_DIV  = 7'b0100000,
    F_PUSH = 7'b1000000
  } front_state_t;

  front_state_t state_r, state_nxt;

  // Input holding register.
  logic                        hold_v_r;
  logic signed [POS_WIDTH-1:0] hold_px_r, hold_py_r;
  logic signed [QUAT_W-1:0]    hold_qx_r, hold_qy_r, hold_qz_r, hold_qw_r;
  logic                        take;

  // Working registers.
  logic signed [POS_WIDTH-1:0] px_r, py_r;
  logic signed [31:0]          yy_r, zz_r, wz_r, xy_r;
  logic [HEAD_W-1:0]           ma_r, mb_r;
  logic                        sa_r, sb_r;
  logic [ISQ_W-1:0]            sqa_r, sqb_r;
  logic [HEAD_W-1:0]           div_r;
  logic [HEAD_W-1:0]           rem_a_r, rem_b_r;
  logic [QUO_W-1:0]            lo_a_r, lo_b_r;
  logic [QUO_W-1:0]            q_a_r, q_b_r;
  logic [DCNT_W-1:0]           cnt_r;

  logic signed [34:0]          a_full, b_full;
  logic [34:0]                 a_abs, b_abs;
  logic                        degen;
  logic                        sq_done;
  logic [HEAD_W-1:0]           sq_root;
  logic [43:0]                 num_a, num_b;
  logic [HEAD_W:0]             trial_a, trial_b;
  logic signed [CS_W-1:0]      cos_q, sin_q;

  assign in_ready = !hold_v_r;
  assign take     = (state_r == F_IDLE) && hold_v_r;

  // Holding register: frees the input as soon as the FSM picks the word up.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      hold_v_r <= 1'b1;
    end else if (take) begin
      hold_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_px_r <= in_pose_x;
      hold_py_r <= in_pose_y;
      hold_qx_r <= in_quat_x;
      hold_qy_r <= in_quat_y;
      hold_qz_r <= in_quat_z;
      hold_qw_r <= in_quat_w;
    end
  end

  // Heading vector: a = 2^28 - 2(qy^2+qz^2), b = 2(qw*qz+qx*qy), both truncated /16.
  always_comb begin
    a_full = (35'sd1 <<< 28) - ((35'(yy_r) + 35'(zz_r)) <<< 1);
    b_full = (35'(wz_r) + 35'(xy_r)) <<< 1;
    a_abs  = a_full[34] ? 35'(-a_full) : 35'(a_full);
    b_abs  = b_full[34] ? 35'(-b_full) : 35'(b_full);
  end

  assign degen = (ma_r == '0) && (mb_r == '0);

  // Rounded dividends (m << 14) + r/2; the quotient stays below 2^15.
  assign num_a   = 44'({ma_r, 14'd0}) + 44'(sq_root >> 1);
  assign num_b   = 44'({mb_r, 14'd0}) + 44'(sq_root >> 1);
  assign trial_a = {rem_a_r, lo_a_r[QUO_W-1]};
  assign trial_b = {rem_b_r, lo_b_r[QUO_W-1]};

  rcrs_isqrt #(
    .IN_W (ISQ_W)
  ) u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == F_SQST),
    .x_in  (sqa_r + sqb_r),
    .done  (sq_done),
    .root  (sq_root)
  );

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE: if (hold_v_r) state_nxt = F_AB;
      F_AB:   state_nxt = F_SQ;
      F_SQ:   state_nxt = degen ? F_PUSH : F_SQST;
      F_SQST: state_nxt = F_SQW;
      F_SQW:  if (sq_done) state_nxt = F_DIV;
      F_DIV:  if (cnt_r == DCNT_W'(1)) state_nxt = F_PUSH;
      F_PUSH: if (push_ready) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath steps of each state.
  always_ff @(posedge clk) begin
    case (state_r)
      F_IDLE: begin
        if (hold_v_r) begin
          px_r <= hold_px_r;
          py_r <= hold_py_r;
          yy_r <= hold_qy_r * hold_qy_r;
          zz_r <= hold_qz_r * hold_qz_r;
          wz_r <= hold_qw_r * hold_qz_r;
          xy_r <= hold_qx_r * hold_qy_r;
        end
      end
      F_AB: begin
        ma_r <= a_abs[32:4];
        mb_r <= b_abs[32:4];
        sa_r <= a_full[34];
        sb_r <= b_full[34];
      end
      F_SQ: begin
        sqa_r <= ma_r * ma_r;
        sqb_r <= mb_r * mb_r;
        // Degenerate heading means yaw zero.
        q_a_r <= QUO_W'(16384);
        q_b_r <= '0;
        sa_r  <= degen ? 1'b0 : sa_r;
      end
      F_SQW: begin
        if (sq_done) begin
          div_r   <= sq_root;
          rem_a_r <= num_a[43:15];
          rem_b_r <= num_b[43:15];
          lo_a_r  <= num_a[14:0];
          lo_b_r  <= num_b[14:0];
          q_a_r   <= '0;
          q_b_r   <= '0;
          cnt_r   <= DCNT_W'(QUO_W);
        end
      end
      F_DIV: begin
        if (trial_a >= {1'b0, div_r}) begin
          rem_a_r <= HEAD_W'(trial_a - {1'b0, div_r});
          q_a_r   <= {q_a_r[QUO_W-2:0], 1'b1};
        end else begin
          rem_a_r <= trial_a[HEAD_W-1:0];
          q_a_r   <= {q_a_r[QUO_W-2:0], 1'b0};
        end
        if (trial_b >= {1'b0, div_r}) begin
          rem_b_r <= HEAD_W'(trial_b - {1'b0, div_r});
          q_b_r   <= {q_b_r[QUO_W-2:0], 1'b1};
        end else begin
          rem_b_r <= trial_b[HEAD_W-1:0];
          q_b_r   <= {q_b_r[QUO_W-2:0], 1'b0};
        end
        lo_a_r <= lo_a_r << 1;
        lo_b_r <= lo_b_r << 1;
        cnt_r  <= cnt_r - DCNT_W'(1);
      end
      default: begin
      end
    endcase
  end

  // Apply the signs and hand the word to the queue.
  assign cos_q = sa_r ? -$signed({1'b0, q_a_r}) : $signed({1'b0, q_a_r});
  assign sin_q = sb_r ? -$signed({1'b0, q_b_r}) : $signed({1'b0, q_b_r});

  assign push_valid = (state_r == F_PUSH);
  assign push_data  = {px_r, py_r, cos_q, sin_q};

endmodule

// File: rtl/rcrs_queue.sv
// Small first-in first-out queue between the front and the back end.
// Depends on nothing; payload width and depth come from the instantiating module.
module rcrs_queue #(
  parameter int W     = 64,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push_valid,
  output logic         push_ready,
  input  logic [W-1:0] push_data,
  output logic         pop_valid,
  input  logic         pop_ready,
  output logic [W-1:0] pop_data
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: rtl/rcrs_back.sv
// Back end: places each sensor, intersects its ray with the obstacle circle and
// registers one result word per sensor. Depends on rcrs_pkg and rcrs_isqrt.
module rcrs_back
  import rcrs_pkg::*;
#(
  parameter int POS_WIDTH = POS_W_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              pop_valid,
  output logic                              pop_ready,
  input  logic [2*POS_WIDTH+2*CS_W-1:0]     pop_data,
  input  logic [POS_WIDTH-1:0]              obs_x,
  input  logic [POS_WIDTH-1:0]              obs_y,
  input  logic [POS_WIDTH-2:0]              radius,
  input  logic [POS_WIDTH-2:0]              limit,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [SIDX_W-1:0]                 out_sensor_index,
  output logic                              out_hit,
  output logic signed [POS_WIDTH-1:0]       out_hit_x,
  output logic signed [POS_WIDTH-1:0]       out_hit_y,
  output logic [POS_WIDTH-2:0]              out_distance,
  output logic                              out_last
);

  localparam int SX_W  = POS_WIDTH + 2;
  localparam int LW    = POS_WIDTH + 3;
  localparam int PRD_W = LW + DIR_W;
  localparam int TW    = POS_WIDTH + 5;
  localparam int RW    = POS_WIDTH - 1;
  localparam int DF_W  = 2 * RW;
  localparam logic signed [WIDE_W-1:0] POS_MAX = (WIDE_W'(1) <<< (POS_WIDTH - 1)) - 1;
  localparam logic signed [WIDE_W-1:0] POS_MIN = -POS_MAX - 1;

  typedef enum logic [8:0] {
    B_IDLE = 9'b000000001,
    B_GEO  = 9'b000000010,
    B_MUL  = 9'b000000100,
    B_TP   = 9'b000001000,
    B_SQ   = 9'b000010000,
    B_SQST = 9'b000100000,
    B_SQW  = 9'b001000000,
    B_HIT  = 9'b010000000,
    B_RES  = 9'b100000000
  } back_state_t;

  back_state_t state_r, state_nxt;

  logic signed [POS_WIDTH-1:0] px_r, py_r;
  logic signed [CS_W-1:0]      c_r, s_r;
  logic [SIDX_W-1:0]           k_r;
  logic signed [SX_W-1:0]      sx_r, sy_r;
  logic signed [DIR_W-1:0]     dx_r, dy_r;
  logic signed [PRD_W-1:0]     m_xx_r, m_yy_r, m_xy_r, m_yx_r;
  logic signed [TW-1:0]        t_r, d_r;
  logic [RW-1:0]               ap_r;
  logic [DF_W-1:0]             diff_r;
  logic                        res_hit_r;
  logic signed [POS_WIDTH-1:0] res_hx_r, res_hy_r;
  logic [RW-1:0]               res_dist_r;

  logic                        out_valid_r;
  logic [SIDX_W-1:0]           out_idx_r;
  logic                        out_hit_r;
  logic signed [POS_WIDTH-1:0] out_hx_r, out_hy_r;
  logic [RW-1:0]               out_dist_r;
  logic                        out_last_r;

  logic signed [WIDE_W-1:0] cw, sw, mxw, myw, uxw, uyw;
  logic signed [WIDE_W-1:0] sx_w, sy_w, dx_w, dy_w;
  logic signed [LW-1:0]     lx, ly;
  logic signed [WIDE_W-1:0] t_w, p_w, ap_w;
  logic                     miss;
  logic [DF_W-1:0]          rsq, asq;
  logic                     sq_done;
  logic [RW-1:0]            sq_root;
  logic                     hit_c;
  logic signed [WIDE_W-1:0] hx_w, hy_w, hx_sat, hy_sat;
  logic                     load;

  // Sensor pose and ray direction from the cosine/sine pair.
  always_comb begin
    cw   = WIDE_W'(c_r);
    sw   = WIDE_W'(s_r);
    mxw  = WIDE_W'(MOUNT_OFS);
    myw  = WIDE_W'(mount_y(k_r));
    uxw  = WIDE_W'(aim_x(k_r));
    uyw  = WIDE_W'(aim_y(k_r));
    sx_w = WIDE_W'(px_r) + rnd14(mxw * cw - myw * sw);
    sy_w = WIDE_W'(py_r) + rnd14(mxw * sw + myw * cw);
    dx_w = rnd14(uxw * cw - uyw * sw);
    dy_w = rnd14(uxw * sw + uyw * cw);
  end

  // Vector from the sensor to the circle centre.
  assign lx = LW'($signed(obs_x)) - LW'(sx_r);
  assign ly = LW'($signed(obs_y)) - LW'(sy_r);

  // Projection along the ray and perpendicular offset.
  always_comb begin
    t_w  = rnd14(WIDE_W'(m_xx_r) + WIDE_W'(m_yy_r));
    p_w  = rnd14(WIDE_W'(m_xy_r) - WIDE_W'(m_yx_r));
    ap_w = p_w[WIDE_W-1] ? -p_w : p_w;
    miss = t_w[WIDE_W-1] || (ap_w > WIDE_W'(radius));
  end

  assign rsq = DF_W'(radius) * DF_W'(radius);
  assign asq = DF_W'(ap_r) * DF_W'(ap_r);

  rcrs_isqrt #(
    .IN_W (DF_W)
  ) u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == B_SQST),
    .x_in  (diff_r),
    .done  (sq_done),
    .root  (sq_root)
  );

  // Range check and hit point, saturated to the position width.
  always_comb begin
    hit_c  = (d_r > 0) && (WIDE_W'(d_r) < WIDE_W'(limit));
    hx_w   = WIDE_W'(sx_r) + rnd14(WIDE_W'(d_r) * WIDE_W'(dx_r));
    hy_w   = WIDE_W'(sy_r) + rnd14(WIDE_W'(d_r) * WIDE_W'(dy_r));
    hx_sat = (hx_w > POS_MAX) ? POS_MAX : ((hx_w < POS_MIN) ? POS_MIN : hx_w);
    hy_sat = (hy_w > POS_MAX) ? POS_MAX : ((hy_w < POS_MIN) ? POS_MIN : hy_w);
  end

  assign load      = !out_valid_r || out_ready;
  assign pop_ready = (state_r == B_IDLE);

  // Per-sensor sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: if (pop_valid) state_nxt = B_GEO;
      B_GEO:  state_nxt = B_MUL;
      B_MUL:  state_nxt = B_TP;
      B_TP:   state_nxt = miss ? B_RES : B_SQ;
      B_SQ:   state_nxt = B_SQST;
      B_SQST: state_nxt = B_SQW;
      B_SQW:  if (sq_done) state_nxt = B_HIT;
      B_HIT:  state_nxt = B_RES;
      B_RES: begin
        if (load) state_nxt = (k_r == SENS_RIGHT) ? B_IDLE : B_GEO;
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath steps of each state.
  always_ff @(posedge clk) begin
    case (state_r)
      B_IDLE: begin
        if (pop_valid) begin
          {px_r, py_r, c_r, s_r} <= pop_data;
          k_r <= SENS_LEFT;
        end
      end
      B_GEO: begin
        sx_r <= SX_W'(sx_w);
        sy_r <= SX_W'(sy_w);
        dx_r <= DIR_W'(dx_w);
        dy_r <= DIR_W'(dy_w);
      end
      B_MUL: begin
        m_xx_r <= lx * dx_r;
        m_yy_r <= ly * dy_r;
        m_xy_r <= lx * dy_r;
        m_yx_r <= ly * dx_r;
      end
      B_TP: begin
        t_r        <= TW'(t_w);
        ap_r       <= RW'(ap_w);
        res_hit_r  <= 1'b0;
        res_hx_r   <= '0;
        res_hy_r   <= '0;
        res_dist_r <= '0;
      end
      B_SQ: begin
        diff_r <= rsq - asq;
      end
      B_SQW: begin
        if (sq_done) begin
          d_r <= t_r - $signed(TW'(sq_root));
        end
      end
      B_HIT: begin
        res_hit_r  <= hit_c;
        res_hx_r   <= hit_c ? POS_WIDTH'(hx_sat) : '0;
        res_hy_r   <= hit_c ? POS_WIDTH'(hy_sat) : '0;
        res_dist_r <= hit_c ? RW'(d_r) : '0;
      end
      B_RES: begin
        if (load) begin
          k_r <= k_r + SIDX_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // Output register: filled when free or being emptied.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == B_RES && load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == B_RES && load) begin
      out_idx_r  <= k_r;
      out_hit_r  <= res_hit_r;
      out_hx_r   <= res_hx_r;
      out_hy_r   <= res_hy_r;
      out_dist_r <= res_dist_r;
      out_last_r <= (k_r == SENS_RIGHT);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_sensor_index = out_idx_r;
  assign out_hit          = out_hit_r;
  assign out_hit_x        = out_hx_r;
  assign out_hit_y        = out_hy_r;
  assign out_distance     = out_dist_r;
  assign out_last         = out_last_r;

  // The closing word of a pose always belongs to the right sensor.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_last_r |-> out_idx_r == SENS_RIGHT)
    else $error("last flag on a word that is not the right sensor");

  // A hit carries a distance strictly inside the detection range.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_hit_r |-> out_dist_r != '0 && out_dist_r < limit)
    else $error("hit word with a distance outside the range");

  // A miss carries an all-zero hit point and distance.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_hit_r |-> out_hx_r == '0 && out_hy_r == '0 && out_dist_r == '0)
    else $error("miss word with nonzero payload");

endmodule

// File: tb/sv/tb_ray_circle_range_sensor.sv
// Self-checking testbench for the ray/circle range sensor: random poses, obstacle settings
// and handshake idling, with a behavioral predictor of the three sensor results per pose.
// Depends on rcrs_pkg and ray_circle_range_sensor.
`timescale 1ns / 1ps

module tb_ray_circle_range_sensor
  import rcrs_pkg::*;
();

  localparam int PW = 16;

  // One pose word and one sensor word.
  typedef struct packed {
    logic signed [PW-1:0] px;
    logic signed [PW-1:0] py;
    logic signed [15:0]   qx;
    logic signed [15:0]   qy;
    logic signed [15:0]   qz;
    logic signed [15:0]   qw;
  } pose_t;

  typedef struct packed {
    logic [1:0]           idx;
    logic                 hit;
    logic signed [PW-1:0] hx;
    logic signed [PW-1:0] hy;
    logic [PW-2:0]        span;
    logic                 last;
  } sensor_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [PW-1:0] in_pose_x = '0, in_pose_y = '0;
  logic signed [15:0] in_quat_x = '0, in_quat_y = '0, in_quat_z = '0, in_quat_w = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_sensor_index;
  logic out_hit, out_last;
  logic signed [PW-1:0] out_hit_x, out_hit_y;
  logic [PW-2:0] out_distance;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  ray_circle_range_sensor uut (.*);

  always #5 clk = ~clk;

  // Obstacle settings as the predictor sees them.
  logic signed [PW-1:0] obs_x = 16'sd6144;
  logic signed [PW-1:0] obs_y = 16'sd2048;
  logic [PW-2:0] obs_r = 15'd1229;
  logic [PW-2:0] obs_lim = 15'd2048;

  pose_t pending_poses[$];
  sensor_t expected_sensors[$];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_off_cycles = 0;
  int mismatches = 0;

  function automatic longint div_round(longint v);
    longint m;
    m = (v < 0) ? -v : v;
    m = (m + 8192) >>> 14;
    return (v < 0) ? -m : m;
  endfunction

  function automatic longint int_sqrt(longint x);
    longint res, bitv;
    res = 0;
    bitv = 64'sd1 <<< 62;
    while (bitv > x) bitv = bitv >>> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x = x - (res + bitv);
        res = (res >>> 1) + bitv;
      end else begin
        res = res >>> 1;
      end
      bitv = bitv >>> 2;
    end
    return res;
  endfunction

  function automatic longint unit_q14(longint v, longint r);
    longint m;
    m = (v < 0) ? -v : v;
    m = ((m <<< 14) + (r >>> 1)) / r;
    return (v < 0) ? -m : m;
  endfunction

  function automatic longint clamp_pos(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // Append one pose to the list of pending poses.
  task automatic queue_pose(input pose_t p);
    pending_poses.insert(pending_poses.size(), p);
  endtask

  // Predict the left, center and right sensor words for one pose.
  task automatic predict_sensors(input pose_t p);
    longint a, b, c, s, r, mx, my, ux, uy, sx, sy, dx, dy, lx, ly, t, pp, ap, d, half;
    sensor_t w;
    a = (64'sd1 <<< 28) - 2 * (longint'(p.qy) * p.qy + longint'(p.qz) * p.qz);
    b = 2 * (longint'(p.qw) * p.qz + longint'(p.qx) * p.qy);
    a = a / 16;
    b = b / 16;
    if (a == 0 && b == 0) begin
      c = 16384;
      s = 0;
    end else begin
      r = int_sqrt(a * a + b * b);
      c = unit_q14(a, r);
      s = unit_q14(b, r);
    end
    for (int k = 0; k < 3; k++) begin
      mx = 307;
      my = (k == SENS_LEFT) ? 307 : (k == SENS_RIGHT) ? -307 : 0;
      ux = (k == SENS_CENTER) ? 16384 : 11585;
      uy = (k == SENS_LEFT) ? 11585 : (k == SENS_RIGHT) ? -11585 : 0;
      sx = p.px + div_round(mx * c - my * s);
      sy = p.py + div_round(mx * s + my * c);
      dx = div_round(ux * c - uy * s);
      dy = div_round(ux * s + uy * c);
      lx = obs_x - sx;
      ly = obs_y - sy;
      t = div_round(lx * dx + ly * dy);
      pp = div_round(lx * dy - ly * dx);
      ap = (pp < 0) ? -pp : pp;
      w = '0;
      w.idx = 2'(k);
      w.last = (k == 2);
      if (t >= 0 && ap <= obs_r) begin
        half = int_sqrt(longint'(obs_r) * obs_r - ap * ap);
        d = t - half;
        if (d > 0 && d < obs_lim) begin
          w.hit = 1'b1;
          w.span = (PW-1)'(d);
          w.hx = PW'(clamp_pos(sx + div_round(d * dx)));
          w.hy = PW'(clamp_pos(sy + div_round(d * dy)));
        end
      end
      expected_sensors.insert(expected_sensors.size(), w);
    end
  endtask

  // Driver: offers queued poses, idling at random, and predicts on acceptance.
  always @(posedge clk) begin
    pose_t nxt;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        predict_sensors({in_pose_x, in_pose_y, in_quat_x, in_quat_y, in_quat_z, in_quat_w});
      end
      if (!in_valid || in_ready) begin
        if (pending_poses.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_poses.pop_front();
          in_valid <= 1'b1;
          {in_pose_x, in_pose_y, in_quat_x, in_quat_y, in_quat_z, in_quat_w} <= nxt;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compares each accepted sensor word with the oldest prediction.
  always @(posedge clk) begin
    sensor_t got, want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got = '{out_sensor_index, out_hit, out_hit_x, out_hit_y, out_distance, out_last};
        if (expected_sensors.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected word %p", got);
        end else begin
          want = expected_sensors.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
          end
        end
      end
      if (hold_off_cycles > 0) begin
        hold_off_cycles <= hold_off_cycles - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= 4'(idx) << 2;
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_OBS_X:  obs_x = val[PW-1:0];
      REG_OBS_Y:  obs_y = val[PW-1:0];
      REG_RADIUS: obs_r = val[PW-2:0];
      default:    obs_lim = val[PW-2:0];
    endcase
  endtask

  // Wait until every queued pose is sent and every prediction has been met.
  task automatic drain();
    while (pending_poses.size() != 0 || in_valid || expected_sensors.size() != 0)
      @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  function automatic logic signed [15:0] rand_q();
    return 16'($signed($urandom_range(32768)) - 16384);
  endfunction

  // A pose placed near the obstacle when near is set, else anywhere, with a mostly normalized heading.
  task automatic add_pose(input bit near);
    pose_t p;
    int ang;
    real th;
    ang = $urandom_range(359);
    th = ang * 3.14159265 / 360.0;
    p.px = near ? PW'(obs_x - 16'sd3000 + $urandom_range(6000)) : PW'($urandom);
    p.py = near ? PW'(obs_y - 16'sd3000 + $urandom_range(6000)) : PW'($urandom);
    if ($urandom_range(9) < 7) begin
      p.qx = 0;
      p.qy = 0;
      p.qz = 16'($rtoi(16384.0 * $sin(th)));
      p.qw = 16'($rtoi(16384.0 * $cos(th)));
    end else begin
      p.qx = ($urandom_range(3) == 0) ? 16'($urandom) : rand_q();
      p.qy = ($urandom_range(3) == 0) ? 16'($urandom) : rand_q();
      p.qz = rand_q();
      p.qw = rand_q();
    end
    queue_pose(p);
  endtask

  task automatic random_phase(input int n, input int idle, input int stall);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    repeat (n) add_pose($urandom_range(9) < 8);
    drain();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    // Directed: extremes, degenerate and unnormalized quaternions, tangent-ish geometry.
    queue_pose('{16'sh7fff, 16'sh7fff, 16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384});
    queue_pose('{16'sh8000, 16'sh8000, -16'sd16384, -16'sd16384, -16'sd16384, -16'sd16384});
    queue_pose('{16'sd0, 16'sd0, 16'sd11585, 16'sd11585, 16'sd0, 16'sd0});
    queue_pose('{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd16384});
    queue_pose('{16'sd4500, 16'sd2048, 16'sd0, 16'sd0, 16'sd0, 16'sd16384});
    queue_pose('{16'sd4500, 16'sd2048, 16'sd0, 16'sd0, 16'sd0, -16'sd1});
    queue_pose('{16'sd7500, 16'sd2048, 16'sd0, 16'sd0, 16'sd16384, 16'sd0});
    queue_pose('{16'sd4500, 16'sd819, 16'sd0, 16'sd0, 16'sd0, 16'sd16384});
    queue_pose('{16'sd4000, 16'sd1800, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000});
    queue_pose('{16'sd4300, 16'sd1500, 16'sd0, 16'sd0, 16'sd6270, 16'sd15137});
    queue_pose('{16'sd4300, 16'sd2600, 16'sd0, 16'sd0, -16'sd6270, 16'sd15137});
    drain();
    // Receiver holds off long while poses keep coming; then a paused sender.
    write_reg(REG_LIMIT, 32'h7fff);
    hold_off_cycles = 1500;
    random_phase(20, 0, 0);
    random_phase(80, 0, 0);
    write_reg(REG_OBS_X, 32'hffff_8000);
    write_reg(REG_OBS_Y, 32'h7fff);
    write_reg(REG_RADIUS, 32'h7fff);
    random_phase(50, 58, 0);
    write_reg(REG_OBS_X, 32'h7fff);
    write_reg(REG_OBS_Y, 32'hffff_8000);
    write_reg(REG_RADIUS, 32'd0);
    random_phase(30, 0, 58);
    write_reg(REG_LIMIT, 32'd0);
    random_phase(20, 15, 15);
    write_reg(REG_OBS_X, 32'd6144);
    write_reg(REG_OBS_Y, 32'd2048);
    write_reg(REG_RADIUS, 32'd4000);
    write_reg(REG_LIMIT, 32'd6000);
    random_phase(80, 15, 15);
    write_reg(REG_OBS_X, 32'($urandom));
    write_reg(REG_OBS_Y, 32'($urandom));
    write_reg(REG_RADIUS, 32'($urandom_range(32767)));
    write_reg(REG_LIMIT, 32'($urandom_range(32767)));
    random_phase(80, 58, 58);
    if (mismatches == 0 && expected_sensors.size() == 0) begin
      $display("[ray_circle_range_sensor] OK");
    end else begin
      $display("[ray_circle_range_sensor] ERROR");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #20ms;
    $display("[ray_circle_range_sensor] ERROR");
    $finish;
  end

endmodule

// File: files.f
rtl/rcrs_pkg.sv
rtl/rcrs_isqrt.sv
rtl/rcrs_front.sv
rtl/rcrs_queue.sv
rtl/rcrs_back.sv
rtl/ray_circle_range_sensor.sv
tb/sv/tb_ray_circle_range_sensor.sv
